FILE: sv/lkv_pkg.sv
package lkv_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AGE_W = IDX_W;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
    logic [AGE_W-1:0]        age;
  } entry_t;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

endpackage

FILE: sv/lkv_entry_ram.sv
module lkv_entry_ram (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [lkv_pkg::IDX_W-1:0] rd_addr,
  output lkv_pkg::entry_t          rd_data,
  input  logic                     wr_en,
  input  logic [lkv_pkg::IDX_W-1:0] wr_addr,
  input  lkv_pkg::entry_t          wr_data
);

  lkv_pkg::entry_t mem [lkv_pkg::DEPTH];
  lkv_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/lkv_engine.sv
module lkv_engine (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lkv_pkg::CAP_W-1:0] cap_i,
  input  logic                     start_i,
  input  lkv_pkg::req_t            req_i,
  output logic                     busy_o,
  output logic                     done_o,
  output lkv_pkg::rsp_t            rsp_o,
  input  logic                     res_ready_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [lkv_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic issue_on_r, issue_on_nxt;
  logic dat_vld_r, dat_vld_nxt;
  logic [lkv_pkg::IDX_W-1:0] dat_idx_r, dat_idx_nxt;
  logic [lkv_pkg::DEPTH-1:0] valid_r, valid_nxt;
  logic [lkv_pkg::CNT_W-1:0] fill_r, fill_nxt;
  lkv_pkg::req_t req_r, req_nxt;
  logic hit_r, hit_nxt;
  logic [lkv_pkg::IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [lkv_pkg::AGE_W-1:0] hit_age_r, hit_age_nxt;
  logic signed [lkv_pkg::VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic old_vld_r, old_vld_nxt;
  logic [lkv_pkg::IDX_W-1:0] old_idx_r, old_idx_nxt;
  logic [lkv_pkg::AGE_W-1:0] old_age_r, old_age_nxt;
  logic signed [lkv_pkg::KEY_W-1:0] old_key_r, old_key_nxt;
  logic free_vld_r, free_vld_nxt;
  logic [lkv_pkg::IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic ins_r, ins_nxt;
  logic [lkv_pkg::IDX_W-1:0] tgt_r, tgt_nxt;
  lkv_pkg::rsp_t rsp_r, rsp_nxt;

  logic mem_rd_en;
  logic mem_wr_en;
  lkv_pkg::entry_t mem_rdata;
  lkv_pkg::entry_t mem_wdata;

  logic dat_valid;
  logic key_match;
  logic pass_end;
  logic [lkv_pkg::CMP_W-1:0] eff_cap;
  logic need_evict;

  lkv_entry_ram u_ram (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (idx_r),
    .rd_data (mem_rdata),
    .wr_en   (mem_wr_en),
    .wr_addr (dat_idx_r),
    .wr_data (mem_wdata)
  );

  // Capacity zero acts as one, and anything above the store size as the store size.
  always_comb begin
    if (cap_i == '0) begin
      eff_cap = lkv_pkg::CMP_W'(1);
    end else if (lkv_pkg::CMP_W'(cap_i) > lkv_pkg::CMP_W'(lkv_pkg::DEPTH)) begin
      eff_cap = lkv_pkg::CMP_W'(lkv_pkg::DEPTH);
    end else begin
      eff_cap = lkv_pkg::CMP_W'(cap_i);
    end
  end

  assign need_evict = (lkv_pkg::CMP_W'(fill_r) >= eff_cap) ||
                      (lkv_pkg::CMP_W'(fill_r) >= lkv_pkg::CMP_W'(lkv_pkg::DEPTH));
  assign dat_valid  = valid_r[dat_idx_r];
  assign key_match  = dat_valid && (mem_rdata.key == req_r.key);
  assign pass_end   = dat_vld_r && (dat_idx_r == lkv_pkg::LAST_IDX);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    issue_on_nxt = issue_on_r;
    dat_vld_nxt  = issue_on_r;
    dat_idx_nxt  = idx_r;
    valid_nxt    = valid_r;
    fill_nxt     = fill_r;
    req_nxt      = req_r;
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    hit_age_nxt  = hit_age_r;
    hit_val_nxt  = hit_val_r;
    old_vld_nxt  = old_vld_r;
    old_idx_nxt  = old_idx_r;
    old_age_nxt  = old_age_r;
    old_key_nxt  = old_key_r;
    free_vld_nxt = free_vld_r;
    free_idx_nxt = free_idx_r;
    ins_nxt      = ins_r;
    tgt_nxt      = tgt_r;
    rsp_nxt      = rsp_r;
    mem_rd_en    = 1'b0;
    mem_wr_en    = 1'b0;
    mem_wdata    = mem_rdata;
    done_o       = 1'b0;

    // Address sequencer shared by both passes over the store.
    if (issue_on_r) begin
      mem_rd_en = 1'b1;
      idx_nxt   = idx_r + lkv_pkg::IDX_W'(1);
      if (idx_r == lkv_pkg::LAST_IDX) begin
        issue_on_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          req_nxt      = req_i;
          hit_nxt      = 1'b0;
          old_vld_nxt  = 1'b0;
          free_vld_nxt = 1'b0;
          idx_nxt      = '0;
          issue_on_nxt = 1'b1;
          state_nxt    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (dat_vld_r) begin
          if (key_match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = dat_idx_r;
            hit_age_nxt = mem_rdata.age;
            hit_val_nxt = mem_rdata.value;
          end
          if (dat_valid && (!old_vld_r || mem_rdata.age > old_age_r)) begin
            old_vld_nxt = 1'b1;
            old_idx_nxt = dat_idx_r;
            old_age_nxt = mem_rdata.age;
            old_key_nxt = mem_rdata.key;
          end
          if (!dat_valid && !free_vld_r) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = dat_idx_r;
          end
        end
        if (pass_end) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        rsp_nxt.found       = hit_r;
        rsp_nxt.read_value  = '0;
        rsp_nxt.evicted     = 1'b0;
        rsp_nxt.evicted_key = '0;
        state_nxt           = S_DONE;
        if (hit_r) begin
          if (req_r.action == lkv_pkg::ACT_GET) begin
            rsp_nxt.read_value = hit_val_r;
          end
          ins_nxt      = 1'b0;
          tgt_nxt      = hit_idx_r;
          idx_nxt      = '0;
          issue_on_nxt = 1'b1;
          state_nxt    = S_UPDATE;
        end else if (req_r.action == lkv_pkg::ACT_GET) begin
          rsp_nxt.read_value = lkv_pkg::MISS_VALUE;
        end else if (need_evict && old_vld_r) begin
          // The evicted slot is refilled at once, so the valid bits and fill hold.
          rsp_nxt.evicted     = 1'b1;
          rsp_nxt.evicted_key = old_key_r;
          ins_nxt             = 1'b1;
          tgt_nxt             = old_idx_r;
          idx_nxt             = '0;
          issue_on_nxt        = 1'b1;
          state_nxt           = S_UPDATE;
        end else if (free_vld_r) begin
          valid_nxt[free_idx_r] = 1'b1;
          fill_nxt              = fill_r + lkv_pkg::CNT_W'(1);
          ins_nxt               = 1'b1;
          tgt_nxt               = free_idx_r;
          idx_nxt               = '0;
          issue_on_nxt          = 1'b1;
          state_nxt             = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (dat_vld_r) begin
          if (dat_idx_r == tgt_r) begin
            mem_wr_en       = 1'b1;
            mem_wdata.key   = req_r.key;
            mem_wdata.value = (req_r.action == lkv_pkg::ACT_PUT) ? req_r.value
                                                                 : mem_rdata.value;
            mem_wdata.age   = '0;
          end else if (dat_valid && (ins_r || mem_rdata.age < hit_age_r)) begin
            mem_wr_en     = 1'b1;
            mem_wdata.age = mem_rdata.age + lkv_pkg::AGE_W'(1);
          end
        end
        if (pass_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done_o = 1'b1;
        if (res_ready_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issue_on_r <= 1'b0;
      dat_vld_r  <= 1'b0;
      valid_r    <= '0;
      fill_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      issue_on_r <= issue_on_nxt;
      dat_vld_r  <= dat_vld_nxt;
      valid_r    <= valid_nxt;
      fill_r     <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    dat_idx_r  <= dat_idx_nxt;
    req_r      <= req_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_age_r  <= hit_age_nxt;
    hit_val_r  <= hit_val_nxt;
    old_vld_r  <= old_vld_nxt;
    old_idx_r  <= old_idx_nxt;
    old_age_r  <= old_age_nxt;
    old_key_r  <= old_key_nxt;
    free_vld_r <= free_vld_nxt;
    free_idx_r <= free_idx_nxt;
    ins_r      <= ins_nxt;
    tgt_r      <= tgt_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign busy_o = (state_r != S_IDLE);
  assign rsp_o  = rsp_r;

  // The occupancy count always equals the number of valid entries.
  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(fill_r))
    else $error("fill count disagrees with valid bits");

  // A write-back never lands on the entry being read in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (dat_idx_r != idx_r))
    else $error("read and write hit the same entry");

  // Writes happen only during the update pass.
  a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (state_r == S_UPDATE))
    else $error("store written outside the update pass");

  // A new request is only started while the engine is idle.
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_o)
    else $error("request started while busy");

endmodule

FILE: sv/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement.
// Each input transfer is a get (action 0) or a put (action 1) of a signed
// 32-bit key and value, and it produces exactly one result transfer that
// reports whether the key was present, the value read (the stored value on a
// get hit, -1 on a get miss, 0 on a put) and the key of any entry evicted to
// make room. Keys, values and recency ages live in one synchronous entry
// memory with a registered read; valid bits and the occupancy count are
// flip-flops cleared by reset, so the block is usable as soon as reset is
// released. Items are handled one at a time: a search pass reads all DEPTH
// entries, a decision state follows, and for anything but a get miss an
// update pass reads every entry and writes back the target entry and each
// entry whose age changes. The two passes over the single entry memory
// set the item rate. in_stall is high while an item is in progress or its
// result waits for the output register; a result held in the output
// register does not hold the engine, so the next input transfer is taken
// while it is still stalled downstream. The capacity register limits how
// many entries are used before eviction starts; zero acts as one and values
// above DEPTH act as DEPTH. Write it only while the block is idle.
module lru_key_value_cache_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]         cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic signed [lkv_pkg::KEY_W-1:0] in_key,
  input  logic signed [lkv_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_found,
  output logic signed [lkv_pkg::VAL_W-1:0] out_read_value,
  output logic                             out_evicted,
  output logic signed [lkv_pkg::KEY_W-1:0] out_evicted_key
);

  logic [lkv_pkg::CAP_W-1:0] cap_r;
  logic out_valid_r, out_valid_nxt;
  lkv_pkg::rsp_t out_rsp_r;

  logic busy;
  logic done;
  logic res_ready;
  logic start;
  lkv_pkg::req_t req;
  lkv_pkg::rsp_t rsp;

  // Capacity register; the write takes effect at the clock edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkv_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  assign in_stall = busy;
  assign start    = in_valid && !busy;

  always_comb begin
    req.action = in_action;
    req.key    = in_key;
    req.value  = in_value;
  end

  lkv_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cap_i       (cap_r),
    .start_i     (start),
    .req_i       (req),
    .busy_o      (busy),
    .done_o      (done),
    .rsp_o       (rsp),
    .res_ready_i (res_ready)
  );

  // The output register can take a new result when it is empty or being drained.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (done && res_ready) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_ready) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_rsp_r.found;
  assign out_read_value  = out_rsp_r.read_value;
  assign out_evicted     = out_rsp_r.evicted;
  assign out_evicted_key = out_rsp_r.evicted_key;

endmodule
